@@ rtl/crt_pkg.sv @@
// Shared types, sizes and codes for the cascaded range translation block.
// Used by crt_table, cascaded_range_translation_top, crt_checker and tb; no dependencies.
`default_nettype none
package crt_pkg;

  // Table sizes
  localparam int MAX_STAGES        = 8;
  localparam int ENTRIES_PER_STAGE = 64;

  // Derived widths
  localparam int STG_W  = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
  localparam int SCNT_W = $clog2(MAX_STAGES + 1);
  localparam int ENT_W  = (ENTRIES_PER_STAGE > 1) ? $clog2(ENTRIES_PER_STAGE) : 1;
  localparam int FILL_W = $clog2(ENTRIES_PER_STAGE + 1);
  localparam int DEPTH  = MAX_STAGES * ENTRIES_PER_STAGE;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Field widths
  localparam int WORD_W = 32;
  localparam int VAL_W  = 33;  // a translated value stays below 2^33
  localparam int LOC_W  = 36;
  localparam int CNT_W  = 4;   // stage_count register
  localparam int CMP_W  = 5;   // room for stage_count and MAX_STAGES alike

  // Action codes
  localparam logic [1:0] ACT_LOAD      = 2'd0;
  localparam logic [1:0] ACT_TRANSLATE = 2'd1;
  localparam logic [1:0] ACT_CLEAR     = 2'd2;

  localparam logic [CNT_W-1:0] STAGE_COUNT_RST = 4'd7;

  typedef struct packed {
    logic [WORD_W-1:0] dest;
    logic [WORD_W-1:0] source;
    logic [WORD_W-1:0] length;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [STG_W-1:0] stage;
    entry_t           entry;
  } tbl_wr_t;

  typedef struct packed {
    logic             en;
    logic [STG_W-1:0] stage;
    logic [ENT_W-1:0] ptr;
  } tbl_rd_t;

  typedef logic [MAX_STAGES-1:0][FILL_W-1:0] fill_arr_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STAGE,
    ST_SCAN,
    ST_DONE
  } state_e;

endpackage
`default_nettype wire

@@ rtl/crt_table.sv @@
// Entry memory for all stage tables plus the per-stage fill counters.
// Depends on crt_pkg.
`default_nettype none
module crt_table (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              clear_i,
  input  wire crt_pkg::tbl_wr_t  wr_i,
  input  wire crt_pkg::tbl_rd_t  rd_i,
  output crt_pkg::entry_t        rd_entry_o,
  output crt_pkg::fill_arr_t     fill_o
);
  import crt_pkg::*;

  entry_t              mem [DEPTH];
  entry_t              rd_q;
  fill_arr_t           fill_q;
  logic [ADDR_W-1:0]   wr_addr;
  logic [ADDR_W-1:0]   rd_addr;

  // Append at the current fill of the target stage
  assign wr_addr = ADDR_W'(ADDR_W'(wr_i.stage) * ADDR_W'(ENTRIES_PER_STAGE))
                 + ADDR_W'(fill_q[wr_i.stage]);
  assign rd_addr = ADDR_W'(ADDR_W'(rd_i.stage) * ADDR_W'(ENTRIES_PER_STAGE))
                 + ADDR_W'(rd_i.ptr);

  // Write and registered read port
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_addr] <= wr_i.entry;
    end
    if (rd_i.en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Advance or drop the fill counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (clear_i) begin
      fill_q <= '0;
    end else if (wr_i.en) begin
      fill_q[wr_i.stage] <= fill_q[wr_i.stage] + FILL_W'(1);
    end
  end

  assign rd_entry_o = rd_q;
  assign fill_o     = fill_q;

endmodule
`default_nettype wire

@@ rtl/cascaded_range_translation_top.sv @@
// Top level of the cascaded range translation block: sequencer, running minimum, result beat.
// Depends on crt_pkg and crt_table.
//
// Load, clear and unused actions are answered directly: the result beat is registered at
// the accepting edge. A translate key walks the active stages in order; each stage passes
// through a set-up state (ST_STAGE) and then a scan state (ST_SCAN) that examines the table
// entries newest first, stopping at the first hit; an empty stage skips the scan state.
// The scan rate is set by the single read port of the entry memory, which delivers one
// entry per cycle to the one shared subtract/compare/add unit.
// The input is not ready while a key is in flight or while a result beat waits.
`default_nettype none
module cascaded_range_translation_top (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // configuration
  input  wire logic                        cfg_we_i,
  input  wire logic [crt_pkg::CNT_W-1:0]   cfg_wdata_i,
  // input channel
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [1:0]                  action_i,
  input  wire logic [2:0]                  stage_i,
  input  wire logic [crt_pkg::WORD_W-1:0]  entry_dest_i,
  input  wire logic [crt_pkg::WORD_W-1:0]  entry_source_i,
  input  wire logic [crt_pkg::WORD_W-1:0]  entry_length_i,
  input  wire logic [crt_pkg::WORD_W-1:0]  key_i,
  // output channel
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [crt_pkg::LOC_W-1:0]        location_o,
  output logic [crt_pkg::LOC_W-1:0]        lowest_location_o,
  output logic                             lowest_valid_o,
  output logic                             status_o
);
  import crt_pkg::*;

  state_e              state_q, state_d;
  logic [SCNT_W-1:0]   stg_q, stg_d;
  logic [ENT_W-1:0]    ptr_q, ptr_d;
  logic [VAL_W-1:0]    val_q, val_d;
  logic [CNT_W-1:0]    stage_count_q;
  logic [LOC_W-1:0]    min_q;
  logic                seen_q;

  logic                out_valid_q;
  logic [LOC_W-1:0]    location_q;
  logic [LOC_W-1:0]    lowest_q;
  logic                lowest_valid_q;
  logic                status_q;

  tbl_wr_t             tbl_wr;
  tbl_rd_t             tbl_rd;
  entry_t              rd_entry;
  fill_arr_t           fill;

  logic                out_free;
  logic                in_fire;
  logic                ld_drop;
  logic [STG_W-1:0]    ld_stage;
  logic                stg_live;
  logic [FILL_W-1:0]   fill_cur;
  logic [VAL_W-1:0]    src_ext;
  logic [VAL_W-1:0]    diff;
  logic                hit;
  logic [VAL_W-1:0]    hit_val;
  logic [LOC_W-1:0]    done_loc;
  logic [LOC_W-1:0]    new_min;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  // Load admission: drop beyond the tables or into a full table
  assign ld_stage = STG_W'(stage_i);
  assign ld_drop  = (CMP_W'(stage_i) >= CMP_W'(MAX_STAGES))
                 || (fill[ld_stage] >= FILL_W'(ENTRIES_PER_STAGE));

  assign tbl_wr.en           = in_fire && (action_i == ACT_LOAD) && !ld_drop;
  assign tbl_wr.stage        = ld_stage;
  assign tbl_wr.entry.dest   = entry_dest_i;
  assign tbl_wr.entry.source = entry_source_i;
  assign tbl_wr.entry.length = entry_length_i;

  crt_table u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (in_fire && (action_i == ACT_CLEAR)),
    .wr_i       (tbl_wr),
    .rd_i       (tbl_rd),
    .rd_entry_o (rd_entry),
    .fill_o     (fill)
  );

  // Shared match unit: one subtract, two compares, one add
  assign src_ext = VAL_W'(rd_entry.source);
  assign diff    = val_q - src_ext;
  assign hit     = (val_q >= src_ext) && (diff < VAL_W'(rd_entry.length));
  assign hit_val = VAL_W'(rd_entry.dest) + diff;

  assign stg_live = (CMP_W'(stg_q) < CMP_W'(stage_count_q))
                 && (CMP_W'(stg_q) < CMP_W'(MAX_STAGES));
  assign fill_cur = fill[stg_q[STG_W-1:0]];

  // Sequencer: next state and memory read request
  always_comb begin
    state_d = state_q;
    stg_d   = stg_q;
    ptr_d   = ptr_q;
    val_d   = val_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && (action_i == ACT_TRANSLATE)) begin
          val_d   = VAL_W'(key_i);
          stg_d   = '0;
          state_d = ST_STAGE;
        end
      end
      ST_STAGE: begin
        if (!stg_live) begin
          state_d = ST_DONE;
        end else if (fill_cur == '0) begin
          stg_d = stg_q + SCNT_W'(1);
        end else begin
          ptr_d   = ENT_W'(fill_cur - FILL_W'(1));
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          val_d   = hit_val;
          stg_d   = stg_q + SCNT_W'(1);
          state_d = ST_STAGE;
        end else if (ptr_q == '0) begin
          stg_d   = stg_q + SCNT_W'(1);
          state_d = ST_STAGE;
        end else begin
          ptr_d = ptr_q - ENT_W'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    tbl_rd.en    = (state_d == ST_SCAN);
    tbl_rd.stage = stg_d[STG_W-1:0];
    tbl_rd.ptr   = ptr_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stg_q <= stg_d;
    ptr_q <= ptr_d;
    val_q <= val_d;
  end

  // Stage count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_count_q <= STAGE_COUNT_RST;
    end else if (cfg_we_i) begin
      stage_count_q <= cfg_wdata_i;
    end
  end

  // Running minimum update for a finished key
  assign done_loc = LOC_W'(val_q);
  assign new_min  = (!seen_q || (done_loc < min_q)) ? done_loc : min_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q  <= '0;
      seen_q <= 1'b0;
    end else if (in_fire && (action_i == ACT_CLEAR)) begin
      min_q  <= '0;
      seen_q <= 1'b0;
    end else if ((state_q == ST_DONE) && out_free) begin
      min_q  <= new_min;
      seen_q <= 1'b1;
    end
  end

  // Result beat: hold until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire && (action_i != ACT_TRANSLATE)) begin
      out_valid_q <= 1'b1;
    end else if ((state_q == ST_DONE) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && (action_i != ACT_TRANSLATE)) begin
      location_q     <= '0;
      lowest_q       <= (action_i == ACT_CLEAR) ? '0 : min_q;
      lowest_valid_q <= (action_i == ACT_CLEAR) ? 1'b0 : seen_q;
      status_q       <= (action_i == ACT_LOAD) && ld_drop;
    end else if ((state_q == ST_DONE) && out_free) begin
      location_q     <= done_loc;
      lowest_q       <= new_min;
      lowest_valid_q <= 1'b1;
      status_q       <= 1'b0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign location_o        = location_q;
  assign lowest_location_o = lowest_q;
  assign lowest_valid_o    = lowest_valid_q;
  assign status_o          = status_q;

endmodule
`default_nettype wire

@@ rtl/crt_checker.sv @@
// Port-level checker for cascaded_range_translation_top, attached by bind.
// Depends on crt_pkg.
`default_nettype none
module crt_checker (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  input  wire logic                        in_ready_o,
  input  wire logic [1:0]                  action_i,
  input  wire logic                        out_valid_o,
  input  wire logic                        out_ready_i,
  input  wire logic [crt_pkg::LOC_W-1:0]   location_o,
  input  wire logic [crt_pkg::LOC_W-1:0]   lowest_location_o,
  input  wire logic                        lowest_valid_o,
  input  wire logic                        status_o
);
  import crt_pkg::*;

  // A stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(location_o)
      && $stable(lowest_location_o) && $stable(status_o))
    else $error("result beat changed while stalled");

  // No minimum is reported before a key has been translated
  a_min_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !lowest_valid_o |-> lowest_location_o == '0)
    else $error("minimum reported while empty");

  // A clear answers at once with an empty minimum
  a_clear_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (action_i == ACT_CLEAR) |=>
      out_valid_o && !lowest_valid_o && (location_o == '0) && !status_o)
    else $error("clear result wrong");

  // A load answers at once with no location
  a_load_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (action_i == ACT_LOAD) |=>
      out_valid_o && (location_o == '0))
    else $error("load result wrong");

endmodule

bind cascaded_range_translation_top crt_checker u_crt_checker (.*);
`default_nettype wire

@@ tb/sv/tb.sv @@
// Self-checking testbench for cascaded_range_translation_top: random and directed beats
// checked against an in-bench model of the staged range tables. Depends on crt_pkg.
`default_nettype none
module tb;
  import crt_pkg::*;

  // Codes not named in the package
  localparam logic [1:0] ACT_UNUSED     = 2'd3;
  localparam logic       STATUS_OK      = 1'b0;
  localparam logic       STATUS_DROPPED = 1'b1;

  localparam int SEG_ITEMS     = 92;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 600;
  localparam int HOLD_CYCLES   = 400;
  localparam int WIN_SPAN      = 2048;
  localparam int LIMIT_CYCLES  = 4_000_000;
  localparam int MAX_REPORTS   = 40;

  typedef struct packed {
    logic [1:0]        action;
    logic [2:0]        stage;
    logic [WORD_W-1:0] dest;
    logic [WORD_W-1:0] source;
    logic [WORD_W-1:0] length;
    logic [WORD_W-1:0] key;
  } beat_t;

  typedef struct packed {
    logic [LOC_W-1:0] location;
    logic [LOC_W-1:0] lowest;
    logic             lowest_valid;
    logic             status;
  } outcome_t;

  // Block ports
  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              cfg_we_i       = 1'b0;
  logic [CNT_W-1:0]  cfg_wdata_i    = '0;
  logic              in_valid_i     = 1'b0;
  logic              in_ready_o;
  logic [1:0]        action_i       = '0;
  logic [2:0]        stage_i        = '0;
  logic [WORD_W-1:0] entry_dest_i   = '0;
  logic [WORD_W-1:0] entry_source_i = '0;
  logic [WORD_W-1:0] entry_length_i = '0;
  logic [WORD_W-1:0] key_i          = '0;
  logic              out_valid_o;
  logic              out_ready_i    = 1'b0;
  logic [LOC_W-1:0]  location_o;
  logic [LOC_W-1:0]  lowest_location_o;
  logic              lowest_valid_o;
  logic              status_o;

  cascaded_range_translation_top DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .action_i          (action_i),
    .stage_i           (stage_i),
    .entry_dest_i      (entry_dest_i),
    .entry_source_i    (entry_source_i),
    .entry_length_i    (entry_length_i),
    .key_i             (key_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .location_o        (location_o),
    .lowest_location_o (lowest_location_o),
    .lowest_valid_o    (lowest_valid_o),
    .status_o          (status_o)
  );

  // Stimulus and scoreboard state
  beat_t    pending_beats[$];
  outcome_t expected_outcomes[$];
  beat_t    next_beat;
  int       sent_count    = 0;
  int       taken_count   = 0;
  int       result_count  = 0;
  int       mismatches    = 0;
  int       send_idle_pct = 10;
  int       recv_idle_pct = 61;
  int       holds_asked   = 0;
  int       holds_served  = 0;
  int       hold_left     = 0;
  int       seg_made      = 0;
  int       cycles        = 0;
  logic [WORD_W-1:0] win_base = '0;

  // Model of the translation tables
  logic [WORD_W-1:0] tbl_dest   [DEPTH];
  logic [WORD_W-1:0] tbl_source [DEPTH];
  logic [WORD_W-1:0] tbl_length [DEPTH];
  int unsigned       fill_level [MAX_STAGES];
  logic [LOC_W-1:0]  running_lowest = '0;
  logic              lowest_seen    = 1'b0;
  logic [CNT_W-1:0]  stage_count_mirror = STAGE_COUNT_RST;

  initial begin
    foreach (fill_level[s]) fill_level[s] = 0;
  end

  // Clock, period 2
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Work out the result of one accepted beat and advance the table model
  function automatic outcome_t translate_beat(beat_t b);
    outcome_t         o;
    logic [LOC_W-1:0] value;
    int               active;
    int               idx;
    o = '0;
    case (b.action)
      ACT_LOAD: begin
        if (b.stage >= MAX_STAGES || fill_level[b.stage] >= ENTRIES_PER_STAGE) begin
          o.status = STATUS_DROPPED;
        end else begin
          idx = b.stage * ENTRIES_PER_STAGE + fill_level[b.stage];
          tbl_dest[idx]   = b.dest;
          tbl_source[idx] = b.source;
          tbl_length[idx] = b.length;
          fill_level[b.stage]++;
        end
      end
      ACT_TRANSLATE: begin
        active = (stage_count_mirror > MAX_STAGES) ? MAX_STAGES : stage_count_mirror;
        value  = LOC_W'(b.key);
        for (int s = 0; s < active; s++) begin
          // newest entry wins, so scan from the top of the table down
          for (int n = fill_level[s] - 1; n >= 0; n--) begin
            idx = s * ENTRIES_PER_STAGE + n;
            if (value >= tbl_source[idx] && value - tbl_source[idx] < tbl_length[idx]) begin
              value = tbl_dest[idx] + (value - tbl_source[idx]);
              break;
            end
          end
        end
        o.location = value;
        if (!lowest_seen || value < running_lowest) running_lowest = value;
        lowest_seen = 1'b1;
      end
      ACT_CLEAR: begin
        foreach (fill_level[s]) fill_level[s] = 0;
        running_lowest = '0;
        lowest_seen    = 1'b0;
      end
      default: ;
    endcase
    o.lowest       = running_lowest;
    o.lowest_valid = lowest_seen;
    return o;
  endfunction

  task automatic report_mismatch(string field, logic [LOC_W-1:0] got, logic [LOC_W-1:0] want);
    if (mismatches < MAX_REPORTS)
      $display("tb: %s wrong on result %0d: got %h, want %h", field, result_count, got, want);
    mismatches++;
  endtask

  // Drive the input channel: offer a new beat only once the last one was taken
  always @(negedge clk_i) begin
    if (rst_ni && sent_count == taken_count) begin
      if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        next_beat      = pending_beats.pop_front();
        action_i       <= next_beat.action;
        stage_i        <= next_beat.stage;
        entry_dest_i   <= next_beat.dest;
        entry_source_i <= next_beat.source;
        entry_length_i <= next_beat.length;
        key_i          <= next_beat.key;
        in_valid_i     <= 1'b1;
        sent_count     <= sent_count + 1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Drive output ready: long hold-offs on request, random stalls otherwise
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (holds_asked != holds_served) begin
      out_ready_i  <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      holds_served <= holds_served + 1;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Check result beats first, then record the input beat taken at this edge
  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_outcomes.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("tb: result %0d arrived with nothing expected", result_count);
        mismatches++;
      end else begin
        want = expected_outcomes.pop_front();
        if (location_o !== want.location)
          report_mismatch("location", location_o, want.location);
        if (lowest_location_o !== want.lowest)
          report_mismatch("lowest_location", lowest_location_o, want.lowest);
        if (lowest_valid_o !== want.lowest_valid)
          report_mismatch("lowest_valid", LOC_W'(lowest_valid_o), LOC_W'(want.lowest_valid));
        if (status_o !== want.status)
          report_mismatch("status", LOC_W'(status_o), LOC_W'(want.status));
      end
      result_count++;
    end
    if (rst_ni && in_valid_i && in_ready_o) begin
      expected_outcomes.push_back(translate_beat({action_i, stage_i, entry_dest_i,
                                                  entry_source_i, entry_length_i, key_i}));
      taken_count <= taken_count + 1;
    end
  end

  // End the run if it hangs
  initial begin
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb: FAIL");
    $finish;
  end

  function automatic beat_t junk_beat(logic [1:0] action);
    beat_t b;
    b.action = action;
    b.stage  = $urandom_range(0, 7);
    b.dest   = $urandom;
    b.source = $urandom;
    b.length = $urandom;
    b.key    = $urandom;
    return b;
  endfunction

  function automatic logic [WORD_W-1:0] win_val();
    return win_base + $urandom_range(0, WIN_SPAN - 1);
  endfunction

  task automatic queue_beat(beat_t b);
    pending_beats.push_back(b);
    if (b.action != ACT_UNUSED) seg_made++;
  endtask

  task automatic queue_load(logic [2:0] stage, logic [WORD_W-1:0] dest,
                            logic [WORD_W-1:0] source, logic [WORD_W-1:0] length);
    beat_t b;
    b        = junk_beat(ACT_LOAD);
    b.stage  = stage;
    b.dest   = dest;
    b.source = source;
    b.length = length;
    queue_beat(b);
  endtask

  task automatic queue_key(logic [WORD_W-1:0] key);
    beat_t b;
    b     = junk_beat(ACT_TRANSLATE);
    b.key = key;
    queue_beat(b);
  endtask

  // Wait until every beat is taken and every result is in, then let the block settle
  task automatic settle(int extra);
    while (pending_beats.size() != 0 || sent_count != taken_count ||
           expected_outcomes.size() != 0)
      @(negedge clk_i);
    repeat (extra) @(negedge clk_i);
  endtask

  task automatic write_stage_count(logic [CNT_W-1:0] value);
    settle(SETTLE_CYCLES);
    @(negedge clk_i);
    cfg_we_i           <= 1'b1;
    cfg_wdata_i        <= value;
    stage_count_mirror = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Extremes, overlap order, zero length, unused action and clear
  task automatic queue_directed();
    queue_key('0);
    queue_key('1);
    queue_beat(junk_beat(ACT_UNUSED));
    queue_beat(junk_beat(ACT_CLEAR));
    queue_key(32'd5);
    queue_load(3'd0, '1, '0, '1);
    queue_key(32'hFFFF_FFFE);
    queue_load(3'd1, '0, '1, '1);
    queue_key(32'hFFFF_FFFE);
    queue_load(3'd2, 32'd100, 32'd0, 32'd0);
    queue_load(3'd2, 32'd200, 32'd10, 32'd5);
    queue_load(3'd2, 32'd300, 32'd12, 32'd1);
    queue_key(32'd12);
    queue_key(32'd11);
    queue_key(32'd0);
    queue_load(3'd7, 32'd1, 32'd0, 32'd1);
    queue_load(3'd6, 32'd50, 32'd0, 32'd400);
    queue_key(32'd13);
    queue_beat(junk_beat(ACT_CLEAR));
    queue_key('0);
    queue_beat(junk_beat(ACT_UNUSED));
  endtask

  // Fill one stage past its capacity, then query it
  task automatic queue_fill_burst();
    logic [2:0] stage;
    stage    = $urandom_range(0, 7);
    win_base = $urandom;
    queue_beat(junk_beat(ACT_CLEAR));
    repeat (ENTRIES_PER_STAGE + 2)
      queue_load(stage, win_val(), win_val(), $urandom_range(1, 300));
    repeat (4) queue_key(win_val());
  endtask

  // A short table build followed by keys that mostly land in the loaded ranges
  task automatic queue_query_run();
    int                n_load;
    int                active;
    logic [2:0]        stage;
    logic [WORD_W-1:0] src;
    logic [WORD_W-1:0] len;
    logic [WORD_W-1:0] last_src;
    logic [WORD_W-1:0] last_len;
    case ($urandom_range(0, 3))
      0:       win_base = '0;
      1:       win_base = 32'hFFFF_F000;
      default: win_base = $urandom;
    endcase
    if ($urandom_range(0, 3) == 0) queue_beat(junk_beat(ACT_CLEAR));
    active   = (stage_count_mirror > MAX_STAGES) ? MAX_STAGES : stage_count_mirror;
    n_load   = $urandom_range(1, 6);
    last_src = win_val();
    last_len = 1;
    repeat (n_load) begin
      if (active > 0 && $urandom_range(0, 3) != 0) stage = $urandom_range(0, active - 1);
      else stage = $urandom_range(0, 7);
      src = win_val();
      case ($urandom_range(0, 9))
        0:       len = '0;
        1:       len = $urandom;
        default: len = $urandom_range(1, 600);
      endcase
      queue_load(stage, win_val(), src, len);
      if (len != 0) begin
        last_src = src;
        last_len = len;
      end
    end
    repeat ($urandom_range(2, 6)) begin
      case ($urandom_range(0, 3))
        0, 1:    queue_key(last_src + $urandom_range(0, last_len - 1));
        2:       queue_key(win_val());
        default: queue_key($urandom);
      endcase
    end
  endtask

  // Stage count per segment: three idling phases of four segments each
  logic [CNT_W-1:0] count_plan [12] = '{4'd15, 4'd0, 4'd1, 4'd8, 4'd3, 4'd7,
                                        4'd9, 4'd2, 4'd8, 4'd6, 4'd4, 4'd5};

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    queue_directed();
    for (int phase = 0; phase < 3; phase++) begin
      for (int seg = 0; seg < 4; seg++) begin
        write_stage_count(count_plan[phase * 4 + seg]);
        case (phase)
          0:       begin send_idle_pct = 10; recv_idle_pct = 61; end
          1:       begin send_idle_pct = 61; recv_idle_pct = 10; end
          default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
        endcase
        seg_made = 0;
        if (seg == 0) queue_fill_burst();
        // stall the output for a long stretch while beats keep coming
        if (phase == 2 && (seg == 0 || seg == 2)) holds_asked++;
        while (seg_made < SEG_ITEMS) begin
          if ($urandom_range(0, 99) < 75) queue_query_run();
          else queue_beat(junk_beat(2'($urandom_range(0, 3))));
        end
      end
    end
    settle(DRAIN_CYCLES);
    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
